// ===== design/uau_pkg.sv =====
package uau_pkg;

    localparam int Width = 64;
    localparam int CntW  = $clog2(Width + 1);

    localparam logic [2:0] CmdAdd = 3'd0;
    localparam logic [2:0] CmdSub = 3'd1;
    localparam logic [2:0] CmdMul = 3'd2;
    localparam logic [2:0] CmdDiv = 3'd3;
    localparam logic [2:0] CmdPow = 3'd4;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_STEP,
        OP_DIV_STEP,
        OP_POW_SETUP,
        OP_POW_ACC,
        OP_POW_SQR
    } t_op;

    typedef struct packed {
        t_op             op;
        logic            start_mul;
        logic            mul_sqr;
    } t_cmd;

    typedef struct packed {
        logic [2:0]      cmd;
        logic            mul_done;
        logic            exp_zero;
        logic            exp_lsb;
    } t_status;

endpackage

// ===== design/unsigned_arith_unit.sv =====
// unsigned arithmetic unit: add, subtract, multiply, divide and power on
// 64-bit unsigned words, one result word per input word. add, subtract
// and unused commands are worked out as the input word is loaded;
// multiply runs one shift-add bit a cycle; divide one restoring step a
// cycle, zero divisor included; power runs square-and-multiply on the
// same shift-add multiplier, a multiply and a square per set exponent bit
// and a square per clear one. one word is worked on at a time: the input
// stalls from acceptance until the result word has been taken
module unsigned_arith_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_command,
    input  logic [uau_pkg::Width-1:0]  i_operand_a,
    input  logic [uau_pkg::Width-1:0]  i_operand_b,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [uau_pkg::Width-1:0]  o_result_value,
    output logic [uau_pkg::Width-1:0]  o_remainder_value,
    output logic                       o_carry_flag,
    output logic                       o_zero_divisor_flag
);
    uau_pkg::t_cmd    w_ctl;
    uau_pkg::t_status w_sts;
    logic             w_load;

    uau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall(i_stall),
        .o_stall(o_stall), .o_valid(o_valid), .o_load(w_load),
        .o_ctl(w_ctl), .i_sts(w_sts)
    );

    uau_datapath u_dp (
        .i_clk(i_clk), .i_load(w_load), .i_command(i_command),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .i_ctl(w_ctl), .o_sts(w_sts),
        .o_result_value(o_result_value), .o_remainder_value(o_remainder_value),
        .o_carry_flag(o_carry_flag), .o_zero_divisor_flag(o_zero_divisor_flag)
    );
endmodule

// ===== design/uau_datapath.sv =====
module uau_datapath (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [2:0]                   i_command,
    input  logic [uau_pkg::Width-1:0]    i_operand_a,
    input  logic [uau_pkg::Width-1:0]    i_operand_b,
    input  uau_pkg::t_cmd                i_ctl,
    output uau_pkg::t_status             o_sts,
    output logic [uau_pkg::Width-1:0]    o_result_value,
    output logic [uau_pkg::Width-1:0]    o_remainder_value,
    output logic                         o_carry_flag,
    output logic                         o_zero_divisor_flag
);
    localparam int W = uau_pkg::Width;

    logic [2:0]                r_cmd;
    logic [W-1:0]              r_a, r_b;        // operands / base, exponent
    logic [W-1:0]              r_res, r_rem;
    logic                      r_carry, r_zdiv, r_base_big;
    // shared shift-add multiplier
    logic [W-1:0]              r_mx, r_my, r_plo, r_phi;
    logic [uau_pkg::CntW-1:0]  r_mcnt;
    logic [W-1:0]              n_phi;
    logic                      n_pc;
    logic [W:0]                n_sum, n_trial;

    always_comb begin
        n_sum = {1'b0, r_phi} + (r_my[0] ? {1'b0, r_mx} : '0);
        n_phi = n_sum[W:1];
        n_pc  = n_sum[0];
        n_trial = {r_rem, r_a[W-1]} - {1'b0, r_b};
    end

    wire w_big = (r_phi != '0);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= i_command;
            r_a <= i_operand_a;
            r_b <= i_operand_b;
            r_rem <= '0;
            r_zdiv <= (i_command == uau_pkg::CmdDiv) && (i_operand_b == '0);
            r_base_big <= 1'b0;
            r_mcnt <= '0;
            case (i_command)
                uau_pkg::CmdAdd: {r_carry, r_res} <= {1'b0, i_operand_a} + {1'b0, i_operand_b};
                uau_pkg::CmdSub: begin
                    r_res <= i_operand_a - i_operand_b;
                    r_carry <= i_operand_a < i_operand_b;
                end
                default: begin
                    r_res <= '0;
                    r_carry <= 1'b0;
                end
            endcase
        end else begin
            case (i_ctl.op)
                uau_pkg::OP_NONE: begin
                    if (i_ctl.start_mul) begin
                        r_mcnt <= uau_pkg::CntW'(W);
                        r_phi <= '0;
                        r_plo <= '0;
                        // a*b, acc*base, or base*base when squaring
                        r_mx <= r_a;
                        r_my <= i_ctl.mul_sqr ? r_a :
                                (r_cmd == uau_pkg::CmdPow) ? r_res : r_b;
                    end
                end
                uau_pkg::OP_MUL_STEP: begin
                    r_phi <= n_phi;
                    r_plo <= {n_pc, r_plo[W-1:1]};
                    r_my  <= r_my >> 1;
                    r_mcnt <= r_mcnt - 1'b1;
                end
                uau_pkg::OP_DIV_STEP: begin
                    // restoring divide, quotient shifts into r_a
                    if (!n_trial[W]) begin
                        r_rem <= n_trial[W-1:0];
                        r_a <= {r_a[W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[W-2:0], r_a[W-1]};
                        r_a <= {r_a[W-2:0], 1'b0};
                    end
                    r_res <= {r_a[W-2:0], !n_trial[W]};
                end
                uau_pkg::OP_POW_SETUP: r_res <= W'(1);
                uau_pkg::OP_POW_ACC: begin
                    r_res <= r_plo;
                    if (w_big || r_base_big) r_carry <= 1'b1;
                end
                uau_pkg::OP_POW_SQR: begin
                    r_a <= r_plo;
                    if (w_big) r_base_big <= 1'b1;
                    r_b <= r_b >> 1;
                end
                uau_pkg::OP_LOAD: begin
                    // final multiply result
                    r_res <= r_plo;
                    r_carry <= w_big;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.cmd = r_cmd;
        o_sts.mul_done = (r_mcnt == '0);
        o_sts.exp_zero = (r_b == '0);
        o_sts.exp_lsb = r_b[0];
    end

    assign o_result_value = r_res;
    assign o_remainder_value = r_rem;
    assign o_carry_flag = r_carry;
    assign o_zero_divisor_flag = r_zdiv;
endmodule

// ===== design/uau_ctrl.sv =====
module uau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    output logic              o_stall,
    output logic              o_valid,
    output logic              o_load,
    output uau_pkg::t_cmd     o_ctl,
    input  uau_pkg::t_status  i_sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MUL, S_DIV, S_PCHK, S_PACCM, S_PSQS, S_PSQRM, S_DONE
    } t_state;

    t_state                   r_state;
    logic [uau_pkg::CntW-1:0] r_cnt;

    assign o_stall = !i_rst_n || (r_state != S_IDLE);
    assign o_load = i_valid && !o_stall;

    always_comb begin
        o_ctl = '{op: uau_pkg::OP_NONE, start_mul: 1'b0, mul_sqr: 1'b0};
        case (r_state)
            S_DISPATCH: begin
                if (i_sts.cmd == uau_pkg::CmdMul) o_ctl.start_mul = 1'b1;
                if (i_sts.cmd == uau_pkg::CmdPow) o_ctl.op = uau_pkg::OP_POW_SETUP;
            end
            S_MUL:  if (i_sts.mul_done) o_ctl.op = uau_pkg::OP_LOAD;
                    else o_ctl.op = uau_pkg::OP_MUL_STEP;
            S_DIV:  o_ctl.op = uau_pkg::OP_DIV_STEP;
            S_PCHK: begin
                if (!i_sts.exp_zero && i_sts.exp_lsb) o_ctl.start_mul = 1'b1;
                else if (!i_sts.exp_zero) begin
                    o_ctl.start_mul = 1'b1;
                    o_ctl.mul_sqr = 1'b1;
                end
            end
            S_PACCM: if (i_sts.mul_done) begin
                o_ctl.op = uau_pkg::OP_POW_ACC;
            end else o_ctl.op = uau_pkg::OP_MUL_STEP;
            S_PSQS: begin
                o_ctl.start_mul = 1'b1;
                o_ctl.mul_sqr = 1'b1;
            end
            S_PSQRM: if (i_sts.mul_done) o_ctl.op = uau_pkg::OP_POW_SQR;
                     else o_ctl.op = uau_pkg::OP_MUL_STEP;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    r_cnt <= uau_pkg::CntW'(uau_pkg::Width);
                    case (i_sts.cmd)
                        uau_pkg::CmdMul: r_state <= S_MUL;
                        uau_pkg::CmdDiv: r_state <= S_DIV;
                        uau_pkg::CmdPow: r_state <= S_PCHK;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MUL: if (i_sts.mul_done) r_state <= S_DONE;
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == uau_pkg::CntW'(1)) r_state <= S_DONE;
                end
                S_PCHK: begin
                    if (i_sts.exp_zero) r_state <= S_DONE;
                    else if (i_sts.exp_lsb) r_state <= S_PACCM;
                    else r_state <= S_PSQRM;
                end
                S_PACCM: if (i_sts.mul_done) r_state <= S_PSQS;
                S_PSQS: r_state <= S_PSQRM;
                S_PSQRM: if (i_sts.mul_done) r_state <= S_PCHK;
                S_DONE: begin
                    if (o_valid && !i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        o_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/uau_checker.sv =====
module uau_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_zero_divisor_flag,
    input logic o_carry_flag
);
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accepting while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_zero_divisor_flag && o_carry_flag)) else $error("flag clash");
endmodule

bind unsigned_arith_unit uau_checker u_chk (.*);
